// File: sv/unix_seconds_to_utc_date_assert.svh
// ----------------------------------------------------------------------------
// unix_seconds_to_utc_date assertion macros
// Concurrent assertion wrappers for the checks of the date converter.
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_TO_UTC_DATE_ASSERT_SVH
`define UNIX_SECONDS_TO_UTC_DATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define USUD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define USUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/usud_pkg.sv
// ----------------------------------------------------------------------------
// usud_pkg
// Constants and small helpers for the unix seconds to UTC date converter.
// ----------------------------------------------------------------------------
package usud_pkg;

  // seconds to days: (t >> 7) / 675, exact by reciprocal for 25-bit operands
  localparam int unsigned DayPreShift = 7;
  localparam int unsigned DayDiv      = 675;
  localparam int unsigned DayShift    = 35;
  localparam logic [25:0] DayRecip    =
    26'(((64'd1 << DayShift) + 64'(DayDiv) - 64'd1) / 64'(DayDiv));
  localparam logic [16:0] SecsPerDay  = 17'd86400;

  // day count from 1968-01-01 in a calendar that keeps 2100-02-29
  localparam logic [15:0] DaysFrom1968 = 16'd731;
  localparam logic [15:0] DayMar2100   = 16'd47541;
  localparam logic [16:0] WeekdayEpoch = 17'd4;

  // four-year blocks of 1461 days
  localparam int unsigned BlockDiv    = 1461;
  localparam int unsigned BlockShift  = 27;
  localparam logic [16:0] BlockRecip  =
    17'(((64'd1 << BlockShift) + 64'(BlockDiv) - 64'd1) / 64'(BlockDiv));
  localparam logic [10:0] BlockDays   = 11'(BlockDiv);
  localparam logic [5:0]  Block2100   = 6'd33;
  localparam logic [10:0] YearStart1  = 11'd366;
  localparam logic [10:0] YearStart2  = 11'd731;
  localparam logic [10:0] YearStart3  = 11'd1096;
  localparam logic [7:0]  YearOffset  = 8'd68;

  // time of day
  localparam int unsigned HourDiv     = 3600;
  localparam int unsigned HourShift   = 29;
  localparam logic [17:0] HourRecip   =
    18'(((64'd1 << HourShift) + 64'(HourDiv) - 64'd1) / 64'(HourDiv));
  localparam logic [11:0] SecsPerHour = 12'(HourDiv);
  localparam int unsigned MinDiv      = 60;
  localparam int unsigned MinShift    = 18;
  localparam logic [12:0] MinRecip    =
    13'(((64'd1 << MinShift) + 64'(MinDiv) - 64'd1) / 64'(MinDiv));
  localparam logic [11:0] SecsPerMin  = 12'(MinDiv);

  localparam logic [3:0]  MonthFeb    = 4'd1;

  // first day of month m within the year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'((m > MonthFeb) && leap);
  endfunction

  // a mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [16:0] a);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(a[2:0]) + 6'(a[5:3]) + 6'(a[8:6]) + 6'(a[11:9]) + 6'(a[14:12])
       + 6'(a[16:15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

// File: sv/unix_seconds_to_utc_date.sv
// ----------------------------------------------------------------------------
// unix_seconds_to_utc_date
// Converts unsigned 32-bit unix seconds into the broken-down UTC date.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+---------------------------------
//  request  | in_valid_i  | in_stall_o   | epoch_seconds_i
//  result   | out_valid_o | out_stall_i  | years_since_1900_o .. second_of_minute_o
//
//  one request per cycle unless in_stall_o is high; result passes through an input register,
//  five intermediate stages splitting the constant multiplies, and an output register
//  reset clears the stage valid bits only, payload registers are not reset
//  a stalled result holds each occupied stage whose successor also holds; bubbles collapse
//  in_stall_o rises only when all seven stages hold a request
// ----------------------------------------------------------------------------
`include "unix_seconds_to_utc_date_assert.svh"

module unix_seconds_to_utc_date
  import usud_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  years_since_1900_o,
  output logic [3:0]  month_index_o,
  output logic [4:0]  day_of_month_o,
  output logic [8:0]  day_of_year_o,
  output logic [2:0]  weekday_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o
);

  localparam int unsigned NumStages = 7;
  localparam int unsigned LastStage = NumStages - 1;

  logic [NumStages-1:0] vld_q, vld_d, adv;

  // stage 0: input
  logic [31:0] epoch_q;
  logic [50:0] day_prod;
  logic [15:0] days_d;
  // stage 1
  logic [15:0] days_q;
  logic [16:0] tod1_q, tod_d;
  logic        late_d;
  logic [15:0] fdays_d;
  logic [2:0]  wday_d;
  // stage 2
  logic [16:0] tod2_q;
  logic [15:0] fdays2_q;
  logic        late2_q;
  logic [2:0]  wday2_q;
  logic [32:0] blk_prod;
  logic [34:0] hour_prod;
  // stage 3
  logic [5:0]  blk3_q;
  logic [4:0]  hour3_q;
  logic [15:0] fdays3_q;
  logic [16:0] tod3_q;
  logic        late3_q;
  logic [2:0]  wday3_q;
  logic [10:0] blkday_d;
  logic [11:0] hrsec_d;
  // stage 4
  logic [10:0] blkday4_q;
  logic [11:0] hrsec4_q;
  logic [5:0]  blk4_q;
  logic [4:0]  hour4_q;
  logic        late4_q;
  logic [2:0]  wday4_q;
  logic [1:0]  yr_d;
  logic [10:0] yr_start;
  logic [8:0]  yday_d;
  logic [24:0] min_prod;
  // stage 5
  logic [8:0]  yday5_q;
  logic [1:0]  yr5_q;
  logic        leap5_q;
  logic [5:0]  blk5_q;
  logic [4:0]  hour5_q;
  logic [5:0]  min5_q;
  logic [11:0] hrsec5_q;
  logic        late5_q;
  logic [2:0]  wday5_q;
  logic [3:0]  mon_d;
  logic [4:0]  mday_d;
  logic [8:0]  yday_out_d;
  logic [5:0]  sec_d;
  logic [7:0]  year_d;

  // ---- handshake: a stage moves when it is empty or its successor moves
  always_comb begin
    adv[LastStage] = !vld_q[LastStage] || !out_stall_i;
    for (int k = int'(LastStage) - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[LastStage];

  // ---- stage 0: day count
  assign day_prod = 51'(epoch_q[31:DayPreShift]) * 51'(DayRecip);
  assign days_d   = day_prod[DayShift +: 16];

  // ---- stage 1: time of day, shifted day count, weekday
  always_comb begin
    tod_d   = tod1_q - 17'(34'(days_q) * 34'(SecsPerDay));
    late_d  = days_q >= DayMar2100;
    fdays_d = days_q + DaysFrom1968 + 16'(late_d);
    wday_d  = mod7(17'(days_q) + WeekdayEpoch);
  end

  // ---- stage 2: four-year block and hour
  assign blk_prod  = 33'(fdays2_q) * 33'(BlockRecip);
  assign hour_prod = 35'(tod2_q) * 35'(HourRecip);

  // ---- stage 3: remainders
  always_comb begin
    blkday_d = 11'(fdays3_q - 16'(17'(blk3_q) * 17'(BlockDays)));
    hrsec_d  = 12'(tod3_q - 17'(17'(hour3_q) * 17'(SecsPerHour)));
  end

  // ---- stage 4: year within block, minute
  always_comb begin
    yr_d = 2'(blkday4_q >= YearStart1) + 2'(blkday4_q >= YearStart2)
         + 2'(blkday4_q >= YearStart3);
    case (yr_d)
      2'd0:    yr_start = '0;
      2'd1:    yr_start = YearStart1;
      2'd2:    yr_start = YearStart2;
      2'd3:    yr_start = YearStart3;
      default: yr_start = '0;
    endcase
    yday_d   = 9'(blkday4_q - yr_start);
    min_prod = 25'(hrsec4_q) * 25'(MinRecip);
  end

  // ---- stage 5: month, day, second, year
  always_comb begin
    mon_d = '0;
    for (int m = 1; m < 12; m++) begin
      mon_d = mon_d + 4'(yday5_q >= month_start(4'(m), leap5_q));
    end
    mday_d = 5'(yday5_q - month_start(mon_d, leap5_q) + 9'd1);
    // 2100 keeps a phantom Feb 29 upstream; take it back out of the day of year
    yday_out_d = yday5_q - 9'(late5_q && (blk5_q == Block2100) && (yr5_q == '0));
    sec_d  = 6'(hrsec5_q - 12'(12'(min5_q) * SecsPerMin));
    year_d = YearOffset + {blk5_q, 2'b00} + 8'(yr5_q);
  end

  // ---- payload registers
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      epoch_q <= epoch_seconds_i;
    end
    if (adv[1]) begin
      days_q <= days_d;
      tod1_q <= epoch_q[16:0];
    end
    if (adv[2]) begin
      tod2_q   <= tod_d;
      fdays2_q <= fdays_d;
      late2_q  <= late_d;
      wday2_q  <= wday_d;
    end
    if (adv[3]) begin
      blk3_q   <= blk_prod[BlockShift +: 6];
      hour3_q  <= hour_prod[HourShift +: 5];
      fdays3_q <= fdays2_q;
      tod3_q   <= tod2_q;
      late3_q  <= late2_q;
      wday3_q  <= wday2_q;
    end
    if (adv[4]) begin
      blkday4_q <= blkday_d;
      hrsec4_q  <= hrsec_d;
      blk4_q    <= blk3_q;
      hour4_q   <= hour3_q;
      late4_q   <= late3_q;
      wday4_q   <= wday3_q;
    end
    if (adv[5]) begin
      yday5_q  <= yday_d;
      yr5_q    <= yr_d;
      leap5_q  <= (yr_d == '0);
      blk5_q   <= blk4_q;
      hour5_q  <= hour4_q;
      min5_q   <= min_prod[MinShift +: 6];
      hrsec5_q <= hrsec4_q;
      late5_q  <= late4_q;
      wday5_q  <= wday4_q;
    end
    if (adv[LastStage]) begin
      years_since_1900_o <= year_d;
      month_index_o      <= mon_d;
      day_of_month_o     <= mday_d;
      day_of_year_o      <= yday_out_d;
      weekday_o          <= wday5_q;
      hour_of_day_o      <= hour5_q;
      minute_of_hour_o   <= min5_q;
      second_of_minute_o <= sec_d;
    end
  end

  // ---- assertions
  `USUD_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni,
    in_stall_o, &vld_q, "request stalled while a pipeline stage is empty")

  `USUD_ASSERT_IMPL(a_time_ranges, clk_i, rst_ni,
    out_valid_o, (hour_of_day_o <= 5'd23) && (minute_of_hour_o <= 6'd59)
      && (second_of_minute_o <= 6'd59), "time of day out of range")

  `USUD_ASSERT_IMPL(a_date_ranges, clk_i, rst_ni,
    out_valid_o, (month_index_o <= 4'd11) && (day_of_month_o != 5'd0)
      && (weekday_o <= 3'd6) && (years_since_1900_o >= 8'd70)
      && (years_since_1900_o <= 8'd206), "date field out of range")

  `USUD_ASSERT_IMPL(a_january_yday, clk_i, rst_ni,
    out_valid_o && (month_index_o == 4'd0),
    day_of_year_o == (9'(day_of_month_o) - 9'd1), "january day of year mismatch")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives unix timestamps into the UTC date converter and checks every decoded
// date and time of day against a behavioral calendar predictor, with random
// request gaps and random result stalls.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [8:0] yday;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } utc_date_t;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReports  = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] epoch_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  years_since_1900_o;
  logic [3:0]  month_index_o;
  logic [4:0]  day_of_month_o;
  logic [8:0]  day_of_year_o;
  logic [2:0]  weekday_o;
  logic [4:0]  hour_of_day_o;
  logic [5:0]  minute_of_hour_o;
  logic [5:0]  second_of_minute_o;

  utc_date_t   pending_dates[$];
  utc_date_t   observed_date;
  utc_date_t   expected_date;
  int unsigned requests_sent = 0;
  int unsigned dates_checked = 0;
  int unsigned error_count = 0;
  bit          no_idling = 1'b0;

  unix_seconds_to_utc_date uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .epoch_seconds_i    (epoch_seconds_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .years_since_1900_o (years_since_1900_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o),
    .day_of_year_o      (day_of_year_o),
    .weekday_o          (weekday_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // calendar decode: day count from 0001-01-01, folded into a 400-year cycle
  function automatic utc_date_t decode_epoch(input logic [31:0] t);
    utc_date_t   d;
    int unsigned secs, days, cycles, yidx, leap, yday, mon, mlen, full_year;
    int          rem;
    secs   = t % 86400;
    days   = t / 86400 + 719162;
    cycles = days / 146097;
    days   = days % 146097;
    d.wday = 3'((days + 1) % 7);
    yidx = days / 365;
    rem  = int'(days % 365) - int'(yidx / 4 - yidx / 100 + yidx / 400);
    // year estimate overshoots near the end of a year
    if (rem < 0) begin
      yidx = yidx - 1;
      rem  = rem + 365 + int'(is_leap_year(yidx + 1));
    end
    leap = is_leap_year(yidx + 1);
    yday = rem;
    d.yday = 9'(yday);
    mon = 0;
    for (int m = 0; m < 12; m++) begin
      case (m)
        1:             mlen = 28 + leap;
        3, 5, 8, 10:   mlen = 30;
        default:       mlen = 31;
      endcase
      if (yday >= mlen && mon == m) begin
        yday = yday - mlen;
        mon  = m + 1;
      end
    end
    full_year = cycles * 400 + yidx + 1;
    d.year    = 8'(full_year - 1900);
    d.month   = 4'(mon);
    d.mday    = 5'(yday + 1);
    d.hour    = 5'(secs / 3600);
    d.minute  = 6'((secs % 3600) / 60);
    d.second  = 6'(secs % 60);
    return d;
  endfunction

  function automatic bit dates_match(input utc_date_t a, input utc_date_t b);
    return a.year === b.year && a.month === b.month && a.mday === b.mday
        && a.yday === b.yday && a.wday === b.wday && a.hour === b.hour
        && a.minute === b.minute && a.second === b.second;
  endfunction

  // days from 1970-01-01 to January 1 of year y
  function automatic int unsigned days_to_new_year(input int unsigned y);
    int unsigned n;
    n = 0;
    for (int unsigned yy = 1970; yy < y; yy++) begin
      n = n + 365 + is_leap_year(yy);
    end
    return n;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (no_idling)  return 0;
    if (r < 55)     return 0;
    if (r < 85)     return $urandom_range(3, 1);
    if (r < 97)     return $urandom_range(10, 4);
    return $urandom_range(40, 11);
  endfunction

  task automatic send_timestamp(input logic [31:0] t);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_dates.push_back(decode_epoch(t));
    requests_sent++;
  endtask

  // result stall: runs of random length, mostly open
  initial begin
    int unsigned r;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(99, 0);
      if (no_idling) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (r < 65) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk_i);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(40, 10)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed_date = '{years_since_1900_o, month_index_o, day_of_month_o,
                        day_of_year_o, weekday_o, hour_of_day_o,
                        minute_of_hour_o, second_of_minute_o};
      if (pending_dates.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("ERROR: unexpected result %p", observed_date);
        end
      end else begin
        expected_date = pending_dates.pop_front();
        dates_checked++;
        if (!dates_match(expected_date, observed_date)) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("ERROR: result %0d mismatch", dates_checked);
            $display("  expected %p", expected_date);
            $display("  actual   %p", observed_date);
          end
        end
      end
    end
  end

  // edges of the range, leap days, cycle end, year ends, 2038 rollover
  task automatic test_directed_dates();
    logic [31:0] stamps[$];
    stamps = '{32'd0, 32'd86399, 32'hFFFFFFFF, 32'd4294944000,
               32'd31535999, 32'd31536000, 32'd94694399, 32'd94694400,
               32'd946684799, 32'd946684800, 32'd951782400, 32'd951868799,
               32'd978220800, 32'd978307199, 32'd978307200,
               32'd4107456000, 32'd4107542399, 32'd4107542400,
               32'd4260211199, 32'd2147483647, 32'd2147483648,
               32'h55555555, 32'hAAAAAAAA};
    foreach (stamps[i]) send_timestamp(stamps[i]);
  endtask

  task automatic test_full_range(input int unsigned count);
    repeat (count) send_timestamp($urandom());
  endtask

  // timestamps clustered on midnights, year ends and the end of february
  task automatic test_calendar_edges(input int unsigned count);
    longint unsigned stamp;
    int unsigned     yr;
    int              day;
    int unsigned     sec;
    repeat (count) begin
      yr  = $urandom_range(2106, 1971);
      day = int'(days_to_new_year(yr));
      case ($urandom_range(5, 0))
        0:       day = day - 1;
        1:       day = day;
        2:       day = day + 58;
        3:       day = day + 59;
        4:       day = day + 364;
        default: day = day + 365;
      endcase
      case ($urandom_range(2, 0))
        0:       sec = 0;
        1:       sec = 86399;
        default: sec = $urandom_range(86399, 0);
      endcase
      stamp = longint'(day) * 86400 + sec;
      if (stamp > 64'hFFFFFFFF) begin
        stamp = 64'hFFFFFFFF - $urandom_range(3000000, 0);
      end
      send_timestamp(stamp[31:0]);
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_idling = 1'b1;
    repeat (count) send_timestamp($urandom());
    no_idling = 1'b0;
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("ERROR: timeout with %0d results outstanding", pending_dates.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_dates();
    test_full_range(400);
    test_calendar_edges(330);
    test_back_to_back(100);
    test_full_range(20);
    in_valid_i <= 1'b0;
    while (pending_dates.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("checked %0d dates from %0d requests: range edges, leap days,",
             dates_checked, requests_sent);
    $display("cycle end, year ends and random stamps under gaps and stalls");
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("errors: %0d", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/usud_pkg.sv
sv/unix_seconds_to_utc_date.sv
tb/tb.sv
